[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the settle trigger controller.
// Self-contained; expects a clock named i_clk and an active-low reset i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every clock edge outside reset.
`define ASSERT_IMPLY(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Checks a condition in the cycle after a trigger.
`define ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[hw/rtl/stc_pkg.sv]
// Package of the settle trigger controller: mode, event codes, result struct.
// No dependencies.
`default_nettype none

package stc_pkg;

    localparam int GEN_BITS_DEF = 32;
    localparam int TICKS_W = 16;
    localparam logic [TICKS_W-1:0] SETTLE_TICKS_RST = 16'd100;

    localparam logic [2:0] KIND_MOVE_START = 3'd0;
    localparam logic [2:0] KIND_MOVE_END = 3'd1;
    localparam logic [2:0] KIND_CONTENT = 3'd2;
    localparam logic [2:0] KIND_TICK = 3'd3;
    localparam logic [2:0] KIND_MANUAL = 3'd4;
    localparam logic [2:0] KIND_FINISHED = 3'd5;

    localparam logic [1:0] LENS_DRAGGING = 2'd0;
    localparam logic [1:0] LENS_SETTLING = 2'd1;
    localparam logic [1:0] LENS_PROCESSING = 2'd2;
    localparam logic [1:0] LENS_SHOWING = 2'd3;

    typedef enum logic [3:0] {
        MODE_DRAGGING = 4'b0001,
        MODE_SETTLING = 4'b0010,
        MODE_PROCESSING = 4'b0100,
        MODE_SHOWING = 4'b1000
    } t_mode;

    typedef struct packed {
        logic       request_valid;
        logic       request_manual;
        logic       finish_accepted;
        logic [1:0] lens_mode;
    } t_result;

    function automatic logic [1:0] lens_code(input t_mode mode);
        logic [1:0] code;
        unique case (mode)
            MODE_DRAGGING: code = LENS_DRAGGING;
            MODE_SETTLING: code = LENS_SETTLING;
            MODE_PROCESSING: code = LENS_PROCESSING;
            MODE_SHOWING: code = LENS_SHOWING;
            default: code = LENS_SETTLING;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/stc_step.sv]
// Event decoder of the settle trigger controller: next mode, counters and result.
// Depends on stc_pkg.
`default_nettype none

module stc_step import stc_pkg::*; #(
    parameter int GEN_BITS = GEN_BITS_DEF
) (
    input  wire logic [2:0]         i_kind,
    input  wire logic [31:0]        i_finished_generation,
    input  wire logic [TICKS_W-1:0] i_settle_ticks,
    input  wire t_mode              i_mode,
    input  wire logic [TICKS_W-1:0] i_elapsed,
    input  wire logic [GEN_BITS-1:0] i_gen,
    output t_mode                   o_mode,
    output logic [TICKS_W-1:0]      o_elapsed,
    output logic [GEN_BITS-1:0]     o_gen,
    output t_result                 o_result,
    output logic [31:0]             o_request_generation
);

    localparam int CMP_W = (GEN_BITS > 32) ? GEN_BITS : 32;

    logic [GEN_BITS-1:0] gen_inc;
    logic [CMP_W-1:0] gen_ext;
    logic [CMP_W-1:0] out_ext;
    logic gen_match;
    logic req;
    logic manual;
    logic accepted;
    logic [TICKS_W-1:0] tick_elapsed;

    assign gen_inc = i_gen + GEN_BITS'(1);
    assign gen_ext = CMP_W'(i_gen);
    assign gen_match = (gen_ext == CMP_W'(i_finished_generation));
    assign tick_elapsed = (i_elapsed < i_settle_ticks) ? i_elapsed + TICKS_W'(1) : i_elapsed;

    always_comb begin
        o_mode = i_mode;
        o_elapsed = i_elapsed;
        o_gen = i_gen;
        req = 1'b0;
        manual = 1'b0;
        accepted = 1'b0;
        unique case (i_kind)
            KIND_MOVE_START: begin
                o_gen = gen_inc;
                o_mode = MODE_DRAGGING;
            end
            KIND_MOVE_END: begin
                o_mode = MODE_SETTLING;
                o_elapsed = '0;
            end
            KIND_CONTENT: begin
                if (i_mode == MODE_PROCESSING) begin
                    o_gen = gen_inc;
                end
                if (i_mode != MODE_DRAGGING) begin
                    o_mode = MODE_SETTLING;
                    o_elapsed = '0;
                end
            end
            KIND_TICK: begin
                if (i_mode == MODE_SETTLING) begin
                    o_elapsed = tick_elapsed;
                    req = (tick_elapsed >= i_settle_ticks);
                end
            end
            KIND_MANUAL: begin
                if (i_mode != MODE_DRAGGING) begin
                    req = 1'b1;
                    manual = 1'b1;
                end
            end
            KIND_FINISHED: begin
                if (i_mode == MODE_PROCESSING && gen_match) begin
                    o_mode = MODE_SHOWING;
                    accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (req) begin
            o_gen = gen_inc;
            o_mode = MODE_PROCESSING;
        end
    end

    assign out_ext = CMP_W'(gen_inc);
    assign o_request_generation = req ? out_ext[31:0] : 32'd0;
    assign o_result = '{
        request_valid: req,
        request_manual: manual,
        finish_accepted: accepted,
        lens_mode: lens_code(o_mode)
    };

endmodule

`default_nettype wire

[hw/rtl/settle_trigger_controller.sv]
// Top level of the settle trigger controller: input register, state, result register.
// Depends on stc_pkg, stc_step and assert_macros.svh.
//
// Channel  Direction  Handshake                 Payload
// in       input      i_in_valid / o_in_ready   i_kind, i_finished_generation
// out      output     o_out_valid / i_out_ready request, finish and mode fields
// cfg      input      i_cfg_valid / o_cfg_ready i_cfg_settle_ticks
//
// Each beat passes the input register, then decode into the result register.
// One beat per cycle is sustained while the output is taken.
// The state advances when a beat moves from the input register into the result register.
// A stalled output holds both registers; the input accepts again as soon as space frees.
// Reset is synchronous: mode settling, counters zero, settle ticks 100.
`default_nettype none
`include "assert_macros.svh"

module settle_trigger_controller import stc_pkg::*; #(
    parameter int GEN_BITS = GEN_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_kind,
    input  wire logic [31:0] i_finished_generation,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_request_valid,
    output logic [31:0]      o_request_generation,
    output logic             o_request_manual,
    output logic             o_finish_accepted,
    output logic [1:0]       o_lens_mode,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_settle_ticks
);

    logic r_in_valid;
    logic [2:0] r_kind;
    logic [31:0] r_fin_gen;
    logic r_out_valid;
    t_result r_result;
    logic [31:0] r_req_gen;
    t_mode r_mode;
    logic [TICKS_W-1:0] r_elapsed;
    logic [GEN_BITS-1:0] r_gen;
    logic [TICKS_W-1:0] r_settle_ticks;

    t_mode n_mode;
    logic [TICKS_W-1:0] n_elapsed;
    logic [GEN_BITS-1:0] n_gen;
    t_result n_result;
    logic [31:0] n_req_gen;

    logic advance;
    logic in_take;

    assign advance = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign in_take = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    stc_step #(
        .GEN_BITS(GEN_BITS)
    ) u_step (
        .i_kind(r_kind),
        .i_finished_generation(r_fin_gen),
        .i_settle_ticks(r_settle_ticks),
        .i_mode(r_mode),
        .i_elapsed(r_elapsed),
        .i_gen(r_gen),
        .o_mode(n_mode),
        .o_elapsed(n_elapsed),
        .o_gen(n_gen),
        .o_result(n_result),
        .o_request_generation(n_req_gen)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode <= MODE_SETTLING;
            r_elapsed <= '0;
            r_gen <= '0;
            r_settle_ticks <= SETTLE_TICKS_RST;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_mode <= n_mode;
                r_elapsed <= n_elapsed;
                r_gen <= n_gen;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_settle_ticks <= i_cfg_settle_ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind <= i_kind;
            r_fin_gen <= i_finished_generation;
        end
        if (advance) begin
            r_result <= n_result;
            r_req_gen <= n_req_gen;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_request_valid = r_result.request_valid;
    assign o_request_generation = r_req_gen;
    assign o_request_manual = r_result.request_manual;
    assign o_finish_accepted = r_result.finish_accepted;
    assign o_lens_mode = r_result.lens_mode;

    `ASSERT_IMPLY(a_req_mode, o_out_valid && o_request_valid,
        o_lens_mode == LENS_PROCESSING, "request beat does not report processing")
    `ASSERT_IMPLY(a_fin_mode, o_out_valid && o_finish_accepted,
        o_lens_mode == LENS_SHOWING, "accepted finish does not report showing")
    `ASSERT_IMPLY(a_manual_req, o_out_valid && o_request_manual,
        o_request_valid, "manual flag without a request")
    `ASSERT_NEXT(a_gen_step, 1'b1,
        r_gen == $past(r_gen) || r_gen == $past(r_gen) + GEN_BITS'(1),
        "generation moved by more than one")

endmodule

`default_nettype wire
